### sv/lrs_pkg.sv
package lrs_pkg;

  localparam int MAX_LABELS_DEF = 64;
  localparam int COORD_BITS_DEF = 10;

  localparam int REG_W = 11;
  localparam int LBL_IN_W = 8;
  localparam int LBL_OUT_W = 6;
  localparam int CNT_W = 21;
  localparam int SUM_W = 30;
  localparam int BRD_W = 13;
  localparam int CEN_W = 14;
  localparam int DIV_N_W = SUM_W + 4;

  localparam logic [0:0] REG_NUM_ROWS = 1'b0;
  localparam logic [0:0] REG_NUM_COLS = 1'b1;

  typedef enum logic [2:0] {
    ST_RUN,
    ST_CLEAR,
    ST_READ,
    ST_DIV,
    ST_OUT
  } lrs_state_t;

endpackage

### sv/label_region_statistics_core.sv
// Label region statistics.
// in_ channel: one labelled pixel per item. in_tdata (low bit up): pixel_label[7:0],
// pixel_row[9:0], pixel_col[9:0]; in_tlast = frame_end.
// out_ channel: one result per label 0..highest label seen, tlast on the final one.
// cfg_ channel: index 0 num_rows, 1 num_cols (11 bits each, reset 1024).
// Pixels are accumulated by read-modify-write on a per-label memory: a pixel with
// a stored label is read, then written back while in_tready is low; a pixel with
// a dropped label only sets the overflow flag.
// At frame end each label is read and its two Q.4 centroids are divided one after
// the other by a shared restoring divider. Each label goes through read, load,
// the x and y divide steps, then the output register, before the next label is
// read. A stalled receiver just holds the drain until the item is taken.
// After the drain the memory is cleared, one entry a cycle, before the next pixel
// is accepted. Reset starts the same clearing pass.
module label_region_statistics_core
  import lrs_pkg::*;
#(
  parameter int MAX_LABELS = MAX_LABELS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // pixel_label[7:0], pixel_row[17:8], pixel_col[27:18]
  input  logic        in_tlast,   // frame_end
  output logic        out_tvalid,
  input  logic        out_tready,
  // region_label[5:0], pixel_count[26:6], centroid_x_q4[40:27],
  // centroid_y_q4[54:41], border_hits[67:55], region_empty[68],
  // label_overflow[69]
  output logic [71:0] out_tdata,
  output logic        out_tlast,  // last_region
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [10:0] cfg_data
);

  localparam int AW = $clog2(MAX_LABELS);
  localparam int EW = CNT_W + 2 * SUM_W + BRD_W;
  localparam int DCW = $clog2(DIV_N_W + 1);

  logic [EW-1:0] mem [MAX_LABELS];
  logic [EW-1:0] rd_q;
  logic [AW-1:0] rd_a, wr_a;
  logic          wr_en;
  logic [EW-1:0] wr_d;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_a] <= wr_d;
    rd_q <= mem[rd_a];
  end

  lrs_state_t     st_r, st_nxt;
  logic [REG_W-1:0] rows_r, cols_r;
  logic [AW-1:0]  hi_r, hi_nxt, k_r, k_nxt;
  logic           ovf_r, ovf_nxt;
  logic           pend_r, pend_nxt, fend_r, fend_nxt;
  logic [AW-1:0]  pl_r;
  logic [COORD_BITS-1:0] prow_r, pcol_r;
  logic [1:0]     phase_r, phase_nxt;   // 0 x divide, 1 y divide
  logic [DCW-1:0] dc_r, dc_nxt;
  logic [DIV_N_W-1:0] dn_r, dn_nxt;
  logic [CNT_W:0] drem_r, drem_nxt;
  logic [CEN_W-1:0] cx_r, cx_nxt;
  logic [CNT_W-1:0] oc_r;
  logic [SUM_W-1:0] ors_r;
  logic [BRD_W-1:0] ob_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= REG_W'(1024);
      cols_r <= REG_W'(1024);
    end else if (cfg_valid) begin
      if (cfg_index == REG_NUM_ROWS) rows_r <= cfg_data;
      else cols_r <= cfg_data;
    end
  end

  // field split of a stored entry
  logic [CNT_W-1:0] e_cnt;
  logic [SUM_W-1:0] e_rs, e_cs;
  logic [BRD_W-1:0] e_b;
  assign {e_b, e_cs, e_rs, e_cnt} = rd_q;

  logic [LBL_IN_W-1:0]   lbl_in;
  logic [COORD_BITS-1:0] row_in, col_in;
  assign lbl_in = in_tdata[7:0];
  assign row_in = COORD_BITS'(in_tdata[17:8]);
  assign col_in = COORD_BITS'(in_tdata[27:18]);

  logic in_ok;
  assign in_ok = (lbl_in < LBL_IN_W'(MAX_LABELS));

  // accumulate (write-back stage)
  logic [REG_W-1:0] lr, lc;
  logic [2:0] hits;
  logic [CNT_W:0] s_c;
  logic [SUM_W:0] s_r, s_cl;
  logic [BRD_W:0] s_b;
  always_comb begin
    lr = rows_r - REG_W'(1);
    lc = cols_r - REG_W'(1);
    hits = 3'((prow_r == '0)) + 3'(REG_W'(prow_r) == lr)
         + 3'((pcol_r == '0)) + 3'(REG_W'(pcol_r) == lc);
    s_c  = {1'b0, e_cnt} + (CNT_W+1)'(1);
    s_r  = {1'b0, e_rs} + (SUM_W+1)'(prow_r);
    s_cl = {1'b0, e_cs} + (SUM_W+1)'(pcol_r);
    s_b  = {1'b0, e_b} + (BRD_W+1)'(hits);
  end

  // restoring divider step
  logic [CNT_W:0] dtry;
  logic [CNT_W:0] dsub;
  always_comb begin
    dtry = {drem_r[CNT_W-1:0], dn_r[DIV_N_W-1]};
    dsub = dtry - {1'b0, oc_r};
  end

  logic [DIV_N_W-1:0] q_sat_src;
  logic [CEN_W-1:0] q_fin;
  assign q_sat_src = {dn_r[DIV_N_W-2:0], ~dsub[CNT_W]};
  assign q_fin = (q_sat_src > DIV_N_W'((1 << CEN_W) - 1)) ? '1 : CEN_W'(q_sat_src);

  logic out_v_r;
  logic [71:0] od_r;
  logic ol_r;

  always_comb begin
    st_nxt = st_r; hi_nxt = hi_r; k_nxt = k_r; ovf_nxt = ovf_r;
    pend_nxt = 1'b0; fend_nxt = fend_r; phase_nxt = phase_r; dc_nxt = dc_r;
    dn_nxt = dn_r; drem_nxt = drem_r; cx_nxt = cx_r;
    rd_a = pl_r; wr_a = pl_r; wr_en = 1'b0; wr_d = '0;
    in_tready = 1'b0;
    case (st_r)
      ST_RUN: begin
        in_tready = !pend_r;
        if (pend_r) begin
          wr_en = 1'b1;
          wr_d = {s_b[BRD_W] ? {BRD_W{1'b1}} : s_b[BRD_W-1:0],
                  s_cl[SUM_W] ? {SUM_W{1'b1}} : s_cl[SUM_W-1:0],
                  s_r[SUM_W] ? {SUM_W{1'b1}} : s_r[SUM_W-1:0],
                  s_c[CNT_W] ? {CNT_W{1'b1}} : s_c[CNT_W-1:0]};
          if (fend_r) begin
            st_nxt = ST_READ; k_nxt = '0;
          end
        end else if (in_tvalid) begin
          rd_a = AW'(lbl_in);
          fend_nxt = in_tlast;
          if (in_ok) begin
            pend_nxt = 1'b1;
            if (AW'(lbl_in) > hi_r) hi_nxt = AW'(lbl_in);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_tlast && !in_ok) begin
            st_nxt = ST_READ; k_nxt = '0;
          end
        end
      end
      ST_READ: begin
        rd_a = k_r;
        st_nxt = ST_DIV; phase_nxt = 2'd0; dc_nxt = '0;
        drem_nxt = '0;
      end
      ST_DIV: begin
        rd_a = k_r;
        if (dc_r == '0 && phase_r == 2'd0) begin
          dn_nxt = {e_cs, 4'b0}; dc_nxt = DCW'(1);
        end else begin
          dn_nxt = q_sat_src;
          drem_nxt = dsub[CNT_W] ? dtry : dsub;
          dc_nxt = dc_r + DCW'(1);
          if (dc_r == DCW'(DIV_N_W)) begin
            if (phase_r == 2'd0) begin
              cx_nxt = q_fin; phase_nxt = 2'd1; dc_nxt = DCW'(1);
              dn_nxt = {ors_r, 4'b0}; drem_nxt = '0;
            end else begin
              st_nxt = ST_OUT;
            end
          end
        end
      end
      ST_OUT: begin
        if (!out_v_r) begin
          if (k_r == hi_r) begin
            st_nxt = ST_CLEAR; k_nxt = '0;
          end else begin
            k_nxt = k_r + AW'(1); st_nxt = ST_READ;
          end
        end
      end
      ST_CLEAR: begin
        wr_en = 1'b1; wr_a = k_r; wr_d = '0;
        k_nxt = k_r + AW'(1);
        if (k_r == AW'(MAX_LABELS - 1)) begin
          st_nxt = ST_RUN; hi_nxt = '0; ovf_nxt = 1'b0; fend_nxt = 1'b0;
        end
      end
      default: st_nxt = ST_CLEAR;
    endcase
  end

  // output register; loaded on the cycle the y divide finishes
  logic load_out;
  assign load_out = (st_r == ST_DIV) && (phase_r == 2'd1) && (dc_r == DCW'(DIV_N_W));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_CLEAR; k_r <= '0; hi_r <= '0; ovf_r <= 1'b0;
      pend_r <= 1'b0; fend_r <= 1'b0; out_v_r <= 1'b0; phase_r <= 2'd0; dc_r <= '0;
    end else begin
      st_r <= st_nxt; k_r <= k_nxt; hi_r <= hi_nxt; ovf_r <= ovf_nxt;
      pend_r <= pend_nxt; fend_r <= fend_nxt; phase_r <= phase_nxt; dc_r <= dc_nxt;
      if (load_out) out_v_r <= 1'b1;
      else if (out_tready) out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    dn_r <= dn_nxt; drem_r <= drem_nxt; cx_r <= cx_nxt;
    if (in_tready && in_tvalid) begin
      pl_r <= AW'(lbl_in); prow_r <= row_in; pcol_r <= col_in;
    end
    if (st_r == ST_DIV && dc_r == '0 && phase_r == 2'd0) begin
      oc_r <= e_cnt; ors_r <= e_rs; ob_r <= e_b;
    end
    if (load_out) begin
      od_r <= {2'b0, ovf_r, (oc_r == '0),
               ob_r,
               (oc_r == '0) ? CEN_W'(0) : q_fin,
               (oc_r == '0) ? CEN_W'(0) : cx_r,
               oc_r, LBL_OUT_W'(k_r)};
      ol_r <= (k_r == hi_r);
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata = od_r;
  assign out_tlast = ol_r;

endmodule
